@@ rtl/session_table_with_aging_unit_macros.svh @@
// assertion macros for the session table
`ifndef SESSION_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define SESSION_TABLE_WITH_AGING_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("session table assertion failed");
`define STA_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("session table implication failed");
`else
`define STA_ASSERT(lbl, clk, rstn, prop)
`define STA_ASSERT_IMP(lbl, clk, rstn, a, b)
`endif
`endif

@@ rtl/sta_pkg.sv @@
`default_nettype none
package sta_pkg;

  localparam logic [2:0] FUNC_ADMIT  = 3'd0;
  localparam logic [2:0] FUNC_FORGET = 3'd1;
  localparam logic [2:0] FUNC_FIND   = 3'd2;
  localparam logic [2:0] FUNC_DROP   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [3:0] ST_LISTED      = 4'd0;
  localparam logic [3:0] ST_REFRESHED   = 4'd1;
  localparam logic [3:0] ST_INVALID     = 4'd2;
  localparam logic [3:0] ST_FULL        = 4'd3;
  localparam logic [3:0] ST_FOUND       = 4'd4;
  localparam logic [3:0] ST_ABSENT      = 4'd5;
  localparam logic [3:0] ST_DROPPED     = 4'd6;
  localparam logic [3:0] ST_NOT_PRESENT = 4'd7;
  localparam logic [3:0] ST_AGED        = 4'd8;
  localparam logic [3:0] ST_CLEARED     = 4'd9;

  localparam logic [0:0] REG_MAX_LISTINGS = 1'd0;
  localparam logic [0:0] REG_FORGET_AFTER = 1'd1;

  localparam logic [6:0]  MAX_LISTINGS_RST = 7'd64;
  localparam logic [31:0] FORGET_AFTER_RST = 32'd30;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] session_id;
    logic        advert_ok;
    logic [63:0] advert_word;
    logic [1:0]  via;
    logic [31:0] from_addr;
    logic [15:0] from_port;
    logic        authenticated;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [6:0]  count;
    logic [1:0]  found_via;
    logic [31:0] found_addr;
    logic [15:0] found_port;
    logic [63:0] found_advert;
    logic        found_auth;
    logic [31:0] found_last_seen;
  } out_t;

  // token walking down the row of cells
  typedef struct packed {
    logic        active;
    logic        hit;
    logic        free_found;
    logic [1:0]  reach;
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] payload;
    logic        auth;
    logic [31:0] seen;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

@@ rtl/session_table_with_aging_unit.sv @@
// the token walks the row of cells one cell per cycle; its end state is registered, then the
// result is committed to the output register once the output slot is free, and an insert
// is written into its cell at that commit; no new transaction is taken until the commit
// reset: table empty, max_listings 64, forget_after 30; no clearing pass
`default_nettype none
`include "session_table_with_aging_unit_macros.svh"
module session_table_with_aging_unit import sta_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);
  localparam int KW = (CW > 7) ? CW + 1 : 8;

  logic [6:0]  max_listings_q;
  logic [31:0] forget_after_q;
  state_e      state_q, state_d;
  in_t         req_q;
  logic [31:0] oldest_q;
  logic [CW-1:0] used_q, used_d;
  tok_t        fin_tok_q;
  logic [IW-1:0] fin_free_q;
  logic [CW-1:0] fin_removed_q;
  logic        out_valid_q;
  out_t        out_q, res;

  tok_t          tok   [ENTRIES+1];
  logic [IW-1:0] fidx  [ENTRIES+1];
  logic [CW-1:0] remv  [ENTRIES+1];

  logic in_acc, slot_free, commit, ins_en, is_full, res_valid;
  logic [KW-1:0] cap_eff;
  logic [32:0] diff;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == S_FIN) && slot_free;
  assign in_stall_o = (state_q != S_IDLE);

  assign cap_eff = (KW'(max_listings_q) < KW'(ENTRIES)) ? KW'(max_listings_q) : KW'(ENTRIES);
  assign is_full = (KW'(used_q) >= cap_eff) || !fin_tok_q.free_found;
  assign ins_en  = commit && req_q.func == FUNC_ADMIT && req_q.advert_ok &&
                   !fin_tok_q.hit && !is_full;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = in_acc;
    fidx[0]       = '0;
    remv[0]       = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sta_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_i      (in_acc ? in_data_i : req_q),
      .oldest_i   (in_acc ? diff[31:0] : oldest_q),
      .tok_i      (tok[g]),
      .free_idx_i (fidx[g]),
      .removed_i  (remv[g]),
      .ins_i      (ins_en),
      .ins_idx_i  (fin_free_q),
      .tok_o      (tok[g+1]),
      .free_idx_o (fidx[g+1]),
      .removed_o  (remv[g+1])
    );
  end

  // saturating now - forget_after
  always_comb begin
    diff = {1'b0, in_data_i.now} - {1'b0, forget_after_q};
    if (diff[32]) diff = '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_WALK;
      S_WALK: if (tok[ENTRIES].active) state_d = S_FIN;
      S_FIN:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b1;
    used_d    = used_q;
    case (req_q.func)
      FUNC_ADMIT: begin
        if (!req_q.advert_ok) res.status = ST_INVALID;
        else if (fin_tok_q.hit) res.status = ST_REFRESHED;
        else if (is_full) res.status = ST_FULL;
        else begin
          res.status = ST_LISTED;
          used_d     = used_q + CW'(1);
        end
      end
      FUNC_FORGET: begin
        res.status = ST_AGED;
        res.count  = (KW'(fin_removed_q) > KW'(127)) ? 7'd127 : 7'(fin_removed_q);
        used_d     = used_q - fin_removed_q;
      end
      FUNC_FIND: begin
        if (fin_tok_q.hit) begin
          res.status          = ST_FOUND;
          res.found_via       = fin_tok_q.reach;
          res.found_addr      = fin_tok_q.addr;
          res.found_port      = fin_tok_q.port;
          res.found_advert    = fin_tok_q.payload;
          res.found_auth      = fin_tok_q.auth;
          res.found_last_seen = fin_tok_q.seen;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      FUNC_DROP: begin
        if (fin_tok_q.hit) begin
          res.status = ST_DROPPED;
          used_d     = used_q - CW'(1);
        end else begin
          res.status = ST_NOT_PRESENT;
        end
      end
      FUNC_CLEAR: begin
        res.status = ST_CLEARED;
        used_d     = '0;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      max_listings_q <= MAX_LISTINGS_RST;
      forget_after_q <= FORGET_AFTER_RST;
      used_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAX_LISTINGS: max_listings_q <= cfg_data_i[6:0];
          REG_FORGET_AFTER: forget_after_q <= (cfg_data_i == '0) ? FORGET_AFTER_RST
                                                                 : cfg_data_i;
          default: ;
        endcase
      end
      if (commit) begin
        used_q      <= used_d;
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= in_data_i;
      oldest_q <= diff[31:0];
    end
    if (tok[ENTRIES].active) begin
      fin_tok_q     <= tok[ENTRIES];
      fin_free_q    <= fidx[ENTRIES];
      fin_removed_q <= remv[ENTRIES];
    end
    if (commit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `STA_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= CW'(ENTRIES))
  `STA_ASSERT_IMP(a_tok_walk, clk_i, rst_ni, tok[ENTRIES].active, state_q == S_WALK)
  `STA_ASSERT_IMP(a_ins_cap, clk_i, rst_ni, ins_en, KW'(used_q) < cap_eff)
  `STA_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, state_q != S_IDLE, in_stall_o)

endmodule
`default_nettype wire

@@ rtl/sta_cell.sv @@
`default_nettype none
module sta_cell import sta_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int IDX     = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire in_t                          req_i,
  input  wire logic [31:0]                  oldest_i,
  input  wire tok_t                         tok_i,
  input  wire logic [$clog2(ENTRIES)-1:0]   free_idx_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0] removed_i,
  input  wire logic                         ins_i,
  input  wire logic [$clog2(ENTRIES)-1:0]   ins_idx_i,
  output tok_t                              tok_o,
  output logic [$clog2(ENTRIES)-1:0]        free_idx_o,
  output logic [$clog2(ENTRIES+1)-1:0]      removed_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic        valid_q, valid_d;
  logic [63:0] sess_q, payload_q;
  logic [1:0]  reach_q;
  logic [31:0] addr_q, seen_q;
  logic [15:0] port_q;
  logic        auth_q;
  tok_t        tok_q, tok_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [CW-1:0] removed_q, removed_d;

  logic hit, act, aged, my_ins, refresh;

  assign act     = tok_i.active;
  assign hit     = valid_q && (req_i.session_id == sess_q);
  assign aged    = valid_q && (seen_q < oldest_i);
  assign my_ins  = ins_i && (ins_idx_i == MY_IDX);
  assign refresh = act && hit && (req_i.func == FUNC_ADMIT) && req_i.advert_ok;

  always_comb begin
    valid_d = valid_q;
    if (my_ins) begin
      valid_d = 1'b1;
    end else if (act) begin
      if (req_i.func == FUNC_CLEAR) valid_d = 1'b0;
      if (req_i.func == FUNC_FORGET && aged) valid_d = 1'b0;
      if (req_i.func == FUNC_DROP && hit) valid_d = 1'b0;
    end
  end

  always_comb begin
    tok_d      = tok_i;
    free_idx_d = free_idx_i;
    removed_d  = removed_i;
    if (act && hit) begin
      tok_d.hit     = 1'b1;
      tok_d.reach   = reach_q;
      tok_d.addr    = addr_q;
      tok_d.port    = port_q;
      tok_d.payload = payload_q;
      tok_d.auth    = auth_q;
      tok_d.seen    = seen_q;
    end
    if (act && !valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      free_idx_d       = MY_IDX;
    end
    if (act && req_i.func == FUNC_FORGET && aged) begin
      removed_d = removed_i + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    removed_q  <= removed_d;
    if (my_ins) begin
      sess_q    <= req_i.session_id;
      payload_q <= req_i.advert_word;
      reach_q   <= req_i.via;
      addr_q    <= req_i.from_addr;
      port_q    <= req_i.from_port;
      auth_q    <= req_i.authenticated;
      seen_q    <= req_i.now;
    end else if (refresh) begin
      payload_q <= req_i.advert_word;
      auth_q    <= req_i.authenticated;
      seen_q    <= req_i.now;
      // nearer or equal reach takes over the source
      if (req_i.via <= reach_q) begin
        reach_q <= req_i.via;
        addr_q  <= req_i.from_addr;
        port_q  <= req_i.from_port;
      end
    end
  end

  assign tok_o      = tok_q;
  assign free_idx_o = free_idx_q;
  assign removed_o  = removed_q;

endmodule
`default_nettype wire

@@ dv/session_table_with_aging_unit_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module session_table_with_aging_unit_tb;
  import sta_pkg::*;

  localparam int ENTRIES = 64;
  localparam int LATENCY = ENTRIES + 2;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;

  session_table_with_aging_unit #(.ENTRIES(ENTRIES)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // table shadow
  logic        tbl_valid [ENTRIES];
  logic [63:0] tbl_session [ENTRIES];
  logic [63:0] tbl_payload [ENTRIES];
  logic [1:0]  tbl_reach [ENTRIES];
  logic [31:0] tbl_addr [ENTRIES];
  logic [15:0] tbl_port [ENTRIES];
  logic        tbl_auth [ENTRIES];
  logic [31:0] tbl_seen [ENTRIES];
  logic [6:0]  cap_reg;
  logic [31:0] age_limit;

  out_t  expected_q[$];
  int    error_count;
  int    idle_cycles;

  // recently used ids so that hits are common
  logic [63:0] id_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
    error_count++;
  endtask

  function automatic int find_slot(input logic [63:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_session[i] == key) return i;
    return -1;
  endfunction

  function automatic out_t table_outcome(input in_t it);
    out_t r;
    int k;
    int used;
    int cap;
    int removed;
    logic [31:0] oldest;
    r = '0;
    case (it.func)
      FUNC_ADMIT: begin
        if (!it.advert_ok) begin
          r.status = ST_INVALID;
        end else begin
          k = find_slot(it.session_id);
          if (k >= 0) begin
            if (it.via <= tbl_reach[k]) begin
              tbl_reach[k] = it.via;
              tbl_addr[k] = it.from_addr;
              tbl_port[k] = it.from_port;
            end
            tbl_payload[k] = it.advert_word;
            tbl_auth[k] = it.authenticated;
            tbl_seen[k] = it.now;
            r.status = ST_REFRESHED;
          end else begin
            used = 0;
            for (int i = 0; i < ENTRIES; i++) used += tbl_valid[i];
            cap = (cap_reg < ENTRIES) ? cap_reg : ENTRIES;
            if (used >= cap) begin
              r.status = ST_FULL;
            end else begin
              k = 0;
              while (tbl_valid[k]) k++;
              tbl_valid[k] = 1'b1;
              tbl_session[k] = it.session_id;
              tbl_payload[k] = it.advert_word;
              tbl_reach[k] = it.via;
              tbl_addr[k] = it.from_addr;
              tbl_port[k] = it.from_port;
              tbl_auth[k] = it.authenticated;
              tbl_seen[k] = it.now;
              r.status = ST_LISTED;
            end
          end
        end
      end
      FUNC_FORGET: begin
        oldest = (it.now > age_limit) ? it.now - age_limit : 32'd0;
        removed = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (tbl_valid[i] && tbl_seen[i] < oldest) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        r.status = ST_AGED;
        r.count = (removed > 127) ? 7'd127 : 7'(removed);
      end
      FUNC_FIND: begin
        k = find_slot(it.session_id);
        if (k < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.status = ST_FOUND;
          r.found_via = tbl_reach[k];
          r.found_addr = tbl_addr[k];
          r.found_port = tbl_port[k];
          r.found_advert = tbl_payload[k];
          r.found_auth = tbl_auth[k];
          r.found_last_seen = tbl_seen[k];
        end
      end
      FUNC_DROP: begin
        k = find_slot(it.session_id);
        if (k < 0) begin
          r.status = ST_NOT_PRESENT;
        end else begin
          tbl_valid[k] = 1'b0;
          r.status = ST_DROPPED;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        r.status = ST_CLEARED;
      end
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_item(input in_t it, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : gap_len();
    repeat (gap) @(negedge clk_i);
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.func <= FUNC_CLEAR) expected_q.insert(expected_q.size(), table_outcome(it));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // the block is busy for a while anyway, so the extra idle wait costs nothing
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_LISTINGS) cap_reg = val[6:0];
    else age_limit = (val == 0) ? 32'd30 : val;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_t rand_item(input logic [2:0] fn, input logic [31:0] now);
    in_t it;
    it.func = fn;
    if (id_pool.size() != 0 && $urandom_range(0, 3) != 0)
      it.session_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
    else
      it.session_id = rand64();
    it.advert_ok = ($urandom_range(0, 9) != 0);
    it.advert_word = rand64();
    it.via = 2'($urandom());
    it.from_addr = $urandom();
    it.from_port = 16'($urandom());
    it.authenticated = 1'($urandom());
    it.now = now;
    return it;
  endfunction

  task automatic test_directed();
    in_t it;
    write_reg(REG_MAX_LISTINGS, 32'd2);
    write_reg(REG_FORGET_AFTER, 32'd0);
    it = rand_item(FUNC_ADMIT, 32'd0);
    it.session_id = '1; it.advert_ok = 1'b1; it.via = 2'd3;
    it.advert_word = '1; it.from_addr = '1; it.from_port = '1; it.authenticated = 1'b1;
    send_item(it);
    it.via = 2'd0; it.advert_word = '0; it.from_addr = '0; it.from_port = '0;
    it.authenticated = 1'b0; it.now = 32'd5;
    send_item(it);
    it.via = 2'd2; it.now = 32'hffff_ffff;
    send_item(it);
    it.func = FUNC_FIND;
    send_item(it);
    it.func = FUNC_ADMIT; it.session_id = '0; it.advert_ok = 1'b0;
    send_item(it);
    it.advert_ok = 1'b1; it.now = 32'd10;
    send_item(it);
    it.session_id = 64'h1234;
    send_item(it);
    it.func = FUNC_FIND; send_item(it);
    it.func = FUNC_DROP; send_item(it);
    it.session_id = '0; send_item(it);
    it.func = FUNC_FIND; send_item(it);
    it.func = 3'd5; send_item(it);
    it.func = 3'd7; send_item(it);
    it.func = FUNC_FORGET; it.now = 32'd0; send_item(it);
    it.now = 32'hffff_ffff; send_item(it);
    it.func = FUNC_CLEAR; send_item(it);
    wait_drained();
    write_reg(REG_MAX_LISTINGS, 32'd0);
    it.func = FUNC_ADMIT; it.session_id = 64'h55; send_item(it);
    wait_drained();
    write_reg(REG_MAX_LISTINGS, 32'd127);
    write_reg(REG_FORGET_AFTER, 32'hffff_ffff);
    for (int i = 0; i < 3; i++) begin
      it = rand_item(FUNC_ADMIT, 32'hffff_fff0); it.advert_ok = 1'b1;
      send_item(it);
    end
    it.func = FUNC_FORGET; send_item(it);
    wait_drained();
  endtask

  task automatic test_random_phase(input logic [6:0] cap, input logic [31:0] limit,
                                   input int n_items);
    in_t it;
    logic [31:0] now;
    logic [2:0] fn;
    int p;
    write_reg(REG_MAX_LISTINGS, {25'd0, cap});
    write_reg(REG_FORGET_AFTER, limit);
    id_pool.delete();
    now = $urandom_range(0, 1000);
    for (int n = 0; n < n_items; n++) begin
      p = $urandom_range(0, 99);
      if (p < 55) fn = FUNC_ADMIT;
      else if (p < 65) fn = FUNC_FORGET;
      else if (p < 82) fn = FUNC_FIND;
      else if (p < 95) fn = FUNC_DROP;
      else if (p < 97) fn = FUNC_CLEAR;
      else fn = 3'($urandom_range(5, 7));
      now = now + $urandom_range(0, 4);
      it = rand_item(fn, ($urandom_range(0, 49) == 0) ? $urandom() : now);
      if (fn == FUNC_ADMIT && id_pool.size() < 90)
        id_pool.insert(id_pool.size(), it.session_id);
      send_item(it, n % 200 < 20);
    end
    wait_drained();
  endtask

  // result checker with random receiver stalls
  initial begin
    out_t exp_r;
    int stall_len;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data_o.status), 64'd0);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data_o.status !== exp_r.status)
            report_mismatch("status", 64'(out_data_o.status), 64'(exp_r.status));
          if (out_data_o.count !== exp_r.count)
            report_mismatch("count", 64'(out_data_o.count), 64'(exp_r.count));
          if (out_data_o.found_via !== exp_r.found_via)
            report_mismatch("found_via", 64'(out_data_o.found_via), 64'(exp_r.found_via));
          if (out_data_o.found_addr !== exp_r.found_addr)
            report_mismatch("found_addr", 64'(out_data_o.found_addr),
                            64'(exp_r.found_addr));
          if (out_data_o.found_port !== exp_r.found_port)
            report_mismatch("found_port", 64'(out_data_o.found_port),
                            64'(exp_r.found_port));
          if (out_data_o.found_advert !== exp_r.found_advert)
            report_mismatch("found_advert", out_data_o.found_advert, exp_r.found_advert);
          if (out_data_o.found_auth !== exp_r.found_auth)
            report_mismatch("found_auth", 64'(out_data_o.found_auth),
                            64'(exp_r.found_auth));
          if (out_data_o.found_last_seen !== exp_r.found_last_seen)
            report_mismatch("found_last_seen", 64'(out_data_o.found_last_seen),
                            64'(exp_r.found_last_seen));
        end
      end
      @(negedge clk_i);
      stall_len = gap_len();
      if (stall_len > 0 && out_valid_o) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("session_table_with_aging_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cap_reg = MAX_LISTINGS_RST;
    age_limit = FORGET_AFTER_RST;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // first item uses reset values of the registers
    send_item(rand_item(FUNC_FORGET, 32'd100));
    wait_drained();
    test_directed();
    test_random_phase(7'd64, 32'd30, 350);
    test_random_phase(7'd5, 32'd1, 300);
    test_random_phase(7'd1, 32'd200, 200);
    test_random_phase(7'd100, 32'd0, 250);
    test_random_phase(7'd20, 32'hffff_ffff, 200);
    if (error_count == 0) begin
      $display("session_table_with_aging_unit_tb: clean");
    end else begin
      $display("session_table_with_aging_unit_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/sta_pkg.sv
rtl/sta_cell.sv
rtl/session_table_with_aging_unit.sv
dv/session_table_with_aging_unit_tb.sv
